/* src/rotation_matrix_to_zyx_euler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to ZYX Euler angle converter
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_ZYX_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_ZYX_EULER_MACROS_SVH

// Same-cycle implication
`define RMZE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RMZE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rmze_pkg.sv */
// ----------------------------------------------------------------------------
// rmze_pkg
// Constants, angle table and helpers shared by the Euler angle converter.
// ----------------------------------------------------------------------------
package rmze_pkg;

	// Angle datapath: radians in Q.24, wide enough for pi plus overshoot
	localparam int ANG_W = 29;
	localparam int ATAN_N = 24;
	localparam int GUARD_SH = 8;

	localparam logic signed [ANG_W-1:0] ANG_PI = 29'sd52707179;
	localparam logic [15:0] INV_GAIN = 16'd39797;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [14:0] PITCH_LIM = 15'sd12868;
	localparam logic [10:0] MARGIN_RST = 11'd8;

	// Lanes of the first CORDIC row
	localparam int LANE_MAG = 0;
	localparam int LANE_YAW = 1;
	localparam int LANE_RN = 2;
	localparam int LANE_RL = 3;
	localparam int LANES_A = 4;

	typedef enum logic [1:0] {
		LOCK_NONE = 2'd0,
		LOCK_NEG = 2'd1,
		LOCK_POS = 2'd2
	} lock_t;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_N] = '{
		29'sd13176795, 29'sd7778716, 29'sd4110060, 29'sd2086331,
		29'sd1047214, 29'sd524117, 29'sd262123, 29'sd131069,
		29'sd65536, 29'sd32768, 29'sd16384, 29'sd8192,
		29'sd4096, 29'sd2048, 29'sd1024, 29'sd512,
		29'sd256, 29'sd128, 29'sd64, 29'sd32,
		29'sd16, 29'sd8, 29'sd4, 29'sd2
	};

	localparam logic signed [ANG_W:0] Q13_RND = 30'sd1024;

	// Round Q.24 to Q3.13 (floor of z + 1024 over 2048) and saturate to +-lim
	function automatic logic signed [15:0] ang_to_q13(
		input logic signed [ANG_W-1:0] z,
		input logic signed [15:0] lim
	);
		logic signed [ANG_W:0] s;
		logic signed [ANG_W-11:0] r;
		s = $signed({z[ANG_W-1], z}) + Q13_RND;
		r = s[ANG_W:11];
		if (r > lim) begin
			r = (ANG_W-10)'(lim);
		end else if (r < -lim) begin
			r = (ANG_W-10)'(-lim);
		end
		return r[15:0];
	endfunction

endpackage

/* src/rmze_ifs.sv */
// ----------------------------------------------------------------------------
// rmze channel interfaces
// Matrix input, angle output and margin configuration channels.
// ----------------------------------------------------------------------------
interface rmze_mat_if #(parameter int SAMPLE_BITS = 16);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] m00;
	logic signed [SAMPLE_BITS-1:0] m01;
	logic signed [SAMPLE_BITS-1:0] m10;
	logic signed [SAMPLE_BITS-1:0] m11;
	logic signed [SAMPLE_BITS-1:0] m20;
	logic signed [SAMPLE_BITS-1:0] m21;
	logic signed [SAMPLE_BITS-1:0] m22;
	modport source (output valid, m00, m01, m10, m11, m20, m21, m22, input ready);
	modport sink (input valid, m00, m01, m10, m11, m20, m21, m22, output ready);
endinterface

interface rmze_ang_if;
	logic valid;
	logic ready;
	logic signed [15:0] yaw;
	logic signed [14:0] pitch;
	logic signed [15:0] roll;
	logic [1:0] gimbal_lock;
	modport source (output valid, yaw, pitch, roll, gimbal_lock, input ready);
	modport sink (input valid, yaw, pitch, roll, gimbal_lock, output ready);
endinterface

interface rmze_cfg_if;
	logic valid;
	logic ready;
	logic [10:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/rmze_prep.sv */
// ----------------------------------------------------------------------------
// rmze_prep
// Pre-rotation for vectoring CORDIC: fold the left half-plane onto the right.
// ----------------------------------------------------------------------------
module rmze_prep
	import rmze_pkg::*;
#(
	parameter int W = 27
) (
	input  logic signed [W-1:0]     x_i,
	input  logic signed [W-1:0]     y_i,
	output logic signed [W-1:0]     x_o,
	output logic signed [W-1:0]     y_o,
	output logic signed [ANG_W-1:0] z_o,
	output logic                    zero_o
);

	// Flag the zero vector; its angle stays 0
	assign zero_o = (x_i == '0) && (y_i == '0);

	// Negate a vector with x < 0 and preload +-pi
	always_comb begin
		if (x_i[W-1]) begin
			x_o = -x_i;
			y_o = -y_i;
			z_o = y_i[W-1] ? -ANG_PI : ANG_PI;
		end else begin
			x_o = x_i;
			y_o = y_i;
			z_o = '0;
		end
	end

endmodule

/* src/rmze_cell.sv */
// ----------------------------------------------------------------------------
// rmze_cell
// One vectoring CORDIC micro-rotation per lane, registered, with handshake.
// ----------------------------------------------------------------------------
module rmze_cell
	import rmze_pkg::*;
#(
	parameter int W = 27,
	parameter int I = 0,
	parameter int LANES = 1,
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_i,
	output logic                              ready_o,
	input  logic [LANES-1:0][W-1:0]           x_i,
	input  logic [LANES-1:0][W-1:0]           y_i,
	input  logic [LANES-1:0][ANG_W-1:0]       z_i,
	input  logic [LANES-1:0]                  zero_i,
	input  logic [SIDE_W-1:0]                 side_i,
	output logic                              valid_o,
	input  logic                              ready_i,
	output logic [LANES-1:0][W-1:0]           x_o,
	output logic [LANES-1:0][W-1:0]           y_o,
	output logic [LANES-1:0][ANG_W-1:0]       z_o,
	output logic [LANES-1:0]                  zero_o,
	output logic [SIDE_W-1:0]                 side_o
);

	logic                        valid_q;
	logic                        load;
	logic [LANES-1:0][W-1:0]     x_d, y_d, x_q, y_q;
	logic [LANES-1:0][ANG_W-1:0] z_d, z_q;
	logic [LANES-1:0]            zero_q;
	logic [SIDE_W-1:0]           side_q;

	// Accept when empty or when the neighbour takes the held transfer
	assign ready_o = ~valid_q | ready_i;
	assign load = valid_i & ready_o;

	// Rotate towards y = 0; a zero vector passes untouched
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [W-1:0]     xv, yv, xs, ys;
		logic signed [ANG_W-1:0] zv;
		assign xv = $signed(x_i[l]);
		assign yv = $signed(y_i[l]);
		assign zv = $signed(z_i[l]);
		assign xs = xv >>> I;
		assign ys = yv >>> I;
		assign x_d[l] = zero_i[l] ? x_i[l] : ((yv > 0) ? W'(xv + ys) : W'(xv - ys));
		assign y_d[l] = zero_i[l] ? y_i[l] : ((yv > 0) ? W'(yv - xs) : W'(yv + xs));
		assign z_d[l] = zero_i[l] ? z_i[l] :
			((yv > 0) ? ANG_W'(zv + ATAN_TAB[I]) : ANG_W'(zv - ATAN_TAB[I]));
	end

	// Hold the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	// Capture the rotated vectors
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_d;
			y_q <= y_d;
			z_q <= z_d;
			zero_q <= zero_i;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;
	assign zero_o = zero_q;
	assign side_o = side_q;

endmodule

/* src/rotation_matrix_to_zyx_euler.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_zyx_euler
// ZYX Euler angles (yaw, pitch, roll) in Q3.13 from a Q2.14 rotation matrix.
// ----------------------------------------------------------------------------
// Takes one matrix per clock while mat.ready is high and returns one angle
// set per matrix, in order. With N = min(CORDIC_STAGES, 24), a row of N CORDIC
// cells computes the column magnitude and the yaw and both roll candidates
// in parallel lanes, a gain stage removes the CORDIC gain with a multiplier,
// a second row of N cells computes pitch, and one output register applies
// the gimbal-lock test. Every cell is a registered stage with its own
// ready, so the pipeline keeps filling while a finished result waits.
// gimbal_margin is written through cfg (reset value 8); write it only while
// the pipeline is empty.
`include "rotation_matrix_to_zyx_euler_macros.svh"

module rotation_matrix_to_zyx_euler
	import rmze_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rmze_mat_if.sink   mat,
	rmze_ang_if.source ang,
	rmze_cfg_if.sink   cfg
);

	localparam int NSTG = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
	localparam int W = SAMPLE_BITS + GUARD_SH + 3;
	localparam int PW = W + 16;
	localparam int SB_W = 48;

	function automatic logic signed [W-1:0] scl(input logic signed [SAMPLE_BITS-1:0] v);
		return W'(v) <<< GUARD_SH;
	endfunction

	// Margin register
	logic [10:0] margin_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
		end else if (cfg.valid) begin
			margin_q <= cfg.data;
		end
	end

	// First row: magnitude, yaw and roll candidates
	logic [NSTG:0]                             va, ra;
	logic [NSTG:0][LANES_A-1:0][W-1:0]         xa, ya;
	logic [NSTG:0][LANES_A-1:0][ANG_W-1:0]     za;
	logic [NSTG:0][LANES_A-1:0]                zra;
	logic [NSTG:0][SAMPLE_BITS-1:0]            sa;
	logic signed [LANES_A-1:0][W-1:0]          px, py;
	logic signed [W-1:0]                       m00_sc;

	assign m00_sc = scl(mat.m00);
	assign px[LANE_MAG] = m00_sc[W-1] ? -m00_sc : m00_sc;
	assign py[LANE_MAG] = scl(mat.m10);
	assign px[LANE_YAW] = m00_sc;
	assign py[LANE_YAW] = scl(mat.m10);
	assign px[LANE_RN] = scl(mat.m22);
	assign py[LANE_RN] = scl(mat.m21);
	assign px[LANE_RL] = scl(mat.m11);
	assign py[LANE_RL] = scl(mat.m01);

	assign va[0] = mat.valid;
	assign mat.ready = ra[0];
	assign sa[0] = mat.m20;

	for (genvar l = 0; l < LANES_A; l++) begin : g_prep_a
		rmze_prep #(.W(W)) u_prep (
			.x_i(px[l]), .y_i(py[l]),
			.x_o(xa[0][l]), .y_o(ya[0][l]), .z_o(za[0][l]), .zero_o(zra[0][l])
		);
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_row_a
		rmze_cell #(.W(W), .I(k), .LANES(LANES_A), .SIDE_W(SAMPLE_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_i(va[k]), .ready_o(ra[k]),
			.x_i(xa[k]), .y_i(ya[k]), .z_i(za[k]), .zero_i(zra[k]), .side_i(sa[k]),
			.valid_o(va[k+1]), .ready_i(ra[k+1]),
			.x_o(xa[k+1]), .y_o(ya[k+1]), .z_o(za[k+1]), .zero_o(zra[k+1]),
			.side_o(sa[k+1])
		);
	end

	// Gain removal stage
	logic                          valid_s1;
	logic [PW-1:0]                 prod_s1;
	logic signed [15:0]            yaw_s1, rn_s1, rl_s1;
	logic [SAMPLE_BITS-1:0]        m20_s1;
	logic [NSTG:0]                 vb, rb;

	assign ra[NSTG] = ~valid_s1 | rb[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ra[NSTG]) begin
			valid_s1 <= va[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (va[NSTG] && ra[NSTG]) begin
			prod_s1 <= PW'(xa[NSTG][LANE_MAG]) * PW'(INV_GAIN);
			yaw_s1 <= ang_to_q13($signed(za[NSTG][LANE_YAW]), PI_Q13);
			rn_s1 <= ang_to_q13($signed(za[NSTG][LANE_RN]), PI_Q13);
			rl_s1 <= ang_to_q13($signed(za[NSTG][LANE_RL]), PI_Q13);
			m20_s1 <= sa[NSTG];
		end
	end

	// Second row: pitch
	logic [PW-1:0]                 prod_rnd;
	logic signed [W-1:0]           mag_r, m20_neg;
	logic [NSTG:0][0:0][W-1:0]     xb, yb;
	logic [NSTG:0][0:0][ANG_W-1:0] zb;
	logic [NSTG:0][0:0]            zrb;
	logic [NSTG:0][SB_W-1:0]       sb;

	assign prod_rnd = prod_s1 + PW'(32768);
	assign mag_r = $signed(prod_rnd[PW-1:16]);
	assign m20_neg = -scl(m20_s1);
	assign vb[0] = valid_s1;
	assign sb[0] = {yaw_s1, rn_s1, rl_s1};

	rmze_prep #(.W(W)) u_prep_b (
		.x_i(mag_r), .y_i(m20_neg),
		.x_o(xb[0][0]), .y_o(yb[0][0]), .z_o(zb[0][0]), .zero_o(zrb[0][0])
	);

	for (genvar k = 0; k < NSTG; k++) begin : g_row_b
		rmze_cell #(.W(W), .I(k), .LANES(1), .SIDE_W(SB_W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_i(vb[k]), .ready_o(rb[k]),
			.x_i(xb[k]), .y_i(yb[k]), .z_i(zb[k]), .zero_i(zrb[k]), .side_i(sb[k]),
			.valid_o(vb[k+1]), .ready_i(rb[k+1]),
			.x_o(xb[k+1]), .y_o(yb[k+1]), .z_o(zb[k+1]), .zero_o(zrb[k+1]),
			.side_o(sb[k+1])
		);
	end

	// Gimbal test and output register
	logic                 out_v_q;
	logic signed [15:0]   yaw_q, roll_q;
	logic signed [14:0]   pitch_q;
	lock_t                lock_q;
	logic signed [15:0]   pitch_raw, yaw_p, rn_p, rl_p;
	logic signed [16:0]   lo_thr, hi_thr;

	assign rb[NSTG] = ~out_v_q | ang.ready;
	assign pitch_raw = ang_to_q13($signed(zb[NSTG][0]), HALF_PI_Q13);
	assign yaw_p = $signed(sb[NSTG][47:32]);
	assign rn_p = $signed(sb[NSTG][31:16]);
	assign rl_p = $signed(sb[NSTG][15:0]);
	assign lo_thr = -17'(HALF_PI_Q13) + $signed({6'd0, margin_q});
	assign hi_thr = 17'(HALF_PI_Q13) - $signed({6'd0, margin_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rb[NSTG]) begin
			out_v_q <= vb[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (vb[NSTG] && rb[NSTG]) begin
			if (17'(pitch_raw) < lo_thr) begin
				lock_q <= LOCK_NEG;
				yaw_q <= '0;
				pitch_q <= -PITCH_LIM;
				roll_q <= -rl_p;
			end else if (17'(pitch_raw) > hi_thr) begin
				lock_q <= LOCK_POS;
				yaw_q <= '0;
				pitch_q <= PITCH_LIM;
				roll_q <= rl_p;
			end else begin
				lock_q <= LOCK_NONE;
				yaw_q <= yaw_p;
				pitch_q <= pitch_raw[14:0];
				roll_q <= rn_p;
			end
		end
	end

	assign ang.valid = out_v_q;
	assign ang.yaw = yaw_q;
	assign ang.pitch = pitch_q;
	assign ang.roll = roll_q;
	assign ang.gimbal_lock = lock_q;

	// Checks
	`RMZE_ASSERT_IMP(a_lock_yaw, clk, arst_n,
		ang.valid && (ang.gimbal_lock != LOCK_NONE), ang.yaw == 16'sd0,
		"yaw not zero under gimbal lock")
	`RMZE_ASSERT_IMP(a_lock_pitch, clk, arst_n,
		ang.valid && (ang.gimbal_lock == LOCK_NEG), ang.pitch == -PITCH_LIM,
		"pitch not clamped at negative lock")
	`RMZE_ASSERT_IMP(a_free_pitch, clk, arst_n,
		ang.valid && (ang.gimbal_lock == LOCK_NONE),
		(ang.pitch <= PITCH_LIM) && (ang.pitch >= -PITCH_LIM),
		"pitch out of range")
	`RMZE_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !rb[0], valid_s1,
		"gain stage dropped a stalled transfer")

endmodule
